/* src/mjd_calendar_date_converter_macros.svh */
// Assertion macros shared by the checker of the date converter.
`ifndef MJD_CALENDAR_DATE_CONVERTER_MACROS_SVH
`define MJD_CALENDAR_DATE_CONVERTER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define MJDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define MJDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mjdc_pkg.sv */
package mjdc_pkg;

    typedef struct packed {
        logic        func;
        logic [15:0] mjd_in;
        logic [7:0]  year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] mjd_out;
        logic [7:0]  year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
    } t_out_item;

    typedef enum logic {
        DIR_TO_DATE = 1'b0,
        DIR_TO_MJD  = 1'b1
    } t_dir;

    // Pipeline depth: four year stages, four month stages, one output stage.
    localparam int STG_YR = 4;
    localparam int STG_MO = 4;
    localparam int NSTG   = STG_YR + STG_MO + 1;

    typedef struct packed {
        logic [NSTG-1:0] load;
        logic            in_rdy;
        logic            out_vld;
    } t_ctl;

    // Everything an item carries down the pipeline.
    typedef struct packed {
        logic               func;
        logic [15:0]        mjd;
        logic               nneg;
        logic [22:0]        nabs;
        logic [7:0]         q0;
        logic signed [8:0]  y;
        logic signed [17:0] yd;
        logic signed [17:0] u;
        logic [4:0]         qm0;
        logic signed [5:0]  m;
        logic signed [10:0] md;
        logic signed [8:0]  yk;
        logic [4:0]         mm;
        logic [4:0]         d1;
        logic signed [17:0] yd1;
        logic signed [10:0] md1;
        logic [15:0]        mjd1;
    } t_work;

    // Year estimate: y = trunc((100 * mjd - 1507820) / 36525).
    localparam logic [23:0] YR_MUL = 24'd100;
    localparam logic [23:0] YR_OFS = 24'd1507820;
    localparam logic [23:0] YR_DIV = 24'd36525;
    localparam logic [30:0] YR_RCP = 31'd229;

    // Month estimate: m = trunc((10000 * (mjd - yd - 14956) - 1000) / 306001).
    localparam logic [31:0] MO_MUL  = 32'd10000;
    localparam logic [31:0] MO_FRAC = 32'd1000;
    localparam logic [23:0] MO_DIV  = 24'd306001;
    localparam logic [27:0] MO_RCP  = 28'd27;

    localparam logic signed [17:0] MJD_BASE = 18'sd14956;
    localparam logic signed [19:0] YD_MUL   = 20'sd1461;
    localparam logic [9:0]         MD_MUL   = 10'd30;

    localparam logic [3:0]        MONTH_JAN    = 4'd1;
    localparam logic [3:0]        MONTH_FEB    = 4'd2;
    localparam logic [4:0]        MONTH_SHIFT  = 5'd12;
    localparam logic signed [5:0] MONTH_WRAP0  = 6'sd14;
    localparam logic signed [5:0] MONTH_WRAP1  = 6'sd15;
    localparam logic signed [5:0] MONTH_YEAR   = 6'sd12;

    // floor(3 * a / 5): the part of trunc(a * 30.6001) above 30 * a, for a below 32.
    localparam logic [4:0] MD_FRAC_TAB [32] = '{
        5'd0,  5'd0,  5'd1,  5'd1,  5'd2,  5'd3,  5'd3,  5'd4,
        5'd4,  5'd5,  5'd6,  5'd6,  5'd7,  5'd7,  5'd8,  5'd9,
        5'd9,  5'd10, 5'd10, 5'd11, 5'd12, 5'd12, 5'd13, 5'd13,
        5'd14, 5'd15, 5'd15, 5'd16, 5'd16, 5'd17, 5'd18, 5'd18
    };

    // trunc(y * 365.25), rounding toward zero for negative years.
    function automatic logic signed [17:0] year_days(input logic signed [8:0] y);
        logic signed [19:0] p;
        logic signed [19:0] q;
        p = 20'(y) * YD_MUL;
        q = (p < 20'sd0) ? ((p + 20'sd3) >>> 2) : (p >>> 2);
        return 18'(q);
    endfunction

    // trunc(m * 30.6001), symmetric about zero.
    function automatic logic signed [10:0] month_days(input logic signed [5:0] m);
        logic [4:0]  a;
        logic [9:0]  v;
        logic signed [10:0] s;
        a = m[5] ? 5'(-m) : m[4:0];
        v = 10'(a) * MD_MUL + 10'(MD_FRAC_TAB[a]);
        s = $signed({1'b0, v});
        return m[5] ? -s : s;
    endfunction

endpackage

/* src/mjdc_ctrl.sv */
module mjdc_ctrl
    import mjdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    output t_ctl o_ctl
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] src;

    // A stage takes new data when it is empty or its content moves on.
    always_comb begin
        logic nxt;
        nxt = !i_out_stall;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = !r_vld[i] || nxt;
            nxt    = rdy[i];
        end
        src   = {r_vld[NSTG-2:0], i_in_valid};
        n_vld = (rdy & src) | (~rdy & r_vld);
        o_ctl.load    = rdy & src;
        o_ctl.in_rdy  = rdy[0];
        o_ctl.out_vld = r_vld[NSTG-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

endmodule

/* src/mjdc_yr.sv */
module mjdc_yr
    import mjdc_pkg::*;
(
    input  logic              i_clk,
    input  logic [STG_YR-1:0] i_load,
    input  t_in_item          i_item,
    output t_work             o_work
);

    t_work r_s1, r_s2, r_s3, r_s4;
    t_work n_s1, n_s2, n_s3, n_s4;

    // Stage 1: offset numerator of the year estimate, and the date-side prep.
    always_comb begin
        logic [23:0] p;
        logic        k;
        n_s1      = '0;
        n_s1.func = i_item.func;
        n_s1.mjd  = i_item.mjd_in;
        p = 24'(i_item.mjd_in) * YR_MUL;
        if (p >= YR_OFS) begin
            n_s1.nneg = 1'b0;
            n_s1.nabs = 23'(p - YR_OFS);
        end else begin
            n_s1.nneg = 1'b1;
            n_s1.nabs = 23'(YR_OFS - p);
        end
        k = (i_item.month_in == MONTH_JAN) || (i_item.month_in == MONTH_FEB);
        n_s1.yk = $signed({1'b0, i_item.year_in}) - $signed({8'b0, k});
        n_s1.mm = 5'(i_item.month_in) + 5'd1 + (k ? MONTH_SHIFT : 5'd0);
        n_s1.d1 = i_item.day_in;
    end

    // Stage 2: reciprocal estimate of the quotient, one short at most.
    always_comb begin
        logic [30:0] p;
        n_s2     = r_s1;
        p        = 31'(r_s1.nabs) * YR_RCP;
        n_s2.q0  = p[30:23];
        n_s2.yd1 = year_days($signed(r_s1.yk));
    end

    // Stage 3: remainder check fixes the quotient, then the sign is applied.
    always_comb begin
        logic [23:0] rem;
        logic [7:0]  q;
        n_s3     = r_s2;
        rem      = 24'(r_s2.nabs) - 24'(r_s2.q0) * YR_DIV;
        q        = r_s2.q0 + 8'(rem >= YR_DIV);
        n_s3.y   = r_s2.nneg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        n_s3.md1 = month_days($signed({1'b0, r_s2.mm}));
    end

    // Stage 4: day count of the year; the date-to-MJD sum completes here.
    always_comb begin
        logic signed [17:0] s;
        n_s4    = r_s3;
        n_s4.yd = year_days($signed(r_s3.y));
        s = MJD_BASE + $signed({13'b0, r_s3.d1}) + $signed(r_s3.yd1)
            + 18'($signed(r_s3.md1));
        n_s4.mjd1 = s[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_s1 <= n_s1;
        end
        if (i_load[1]) begin
            r_s2 <= n_s2;
        end
        if (i_load[2]) begin
            r_s3 <= n_s3;
        end
        if (i_load[3]) begin
            r_s4 <= n_s4;
        end
    end

    assign o_work = r_s4;

endmodule

/* src/mjdc_mo.sv */
module mjdc_mo
    import mjdc_pkg::*;
(
    input  logic              i_clk,
    input  logic [STG_MO-1:0] i_load,
    input  t_work             i_work,
    output t_work             o_work
);

    t_work r_s5, r_s6, r_s7, r_s8;
    t_work n_s5, n_s6, n_s7, n_s8;

    // Stage 5: days into the shifted year, scaled for the month estimate.
    always_comb begin
        logic signed [17:0] u;
        logic [17:0]        ua;
        logic [31:0]        p;
        n_s5   = i_work;
        u      = $signed({2'b0, i_work.mjd}) - $signed(i_work.yd) - MJD_BASE;
        n_s5.u = u;
        ua     = (u > 18'sd0) ? 18'(u) : 18'(-u);
        p      = 32'(ua) * MO_MUL;
        if (u > 18'sd0) begin
            n_s5.nneg = 1'b0;
            n_s5.nabs = 23'(p - MO_FRAC);
        end else begin
            n_s5.nneg = 1'b1;
            n_s5.nabs = 23'(p + MO_FRAC);
        end
    end

    // Stage 6: reciprocal estimate of the month quotient.
    always_comb begin
        logic [27:0] p;
        n_s6     = r_s5;
        p        = 28'(r_s5.nabs) * MO_RCP;
        n_s6.qm0 = p[27:23];
    end

    // Stage 7: correction and sign.
    always_comb begin
        logic [23:0] rem;
        logic [4:0]  q;
        n_s7   = r_s6;
        rem    = 24'(r_s6.nabs) - 24'(r_s6.qm0) * MO_DIV;
        q      = r_s6.qm0 + 5'(rem >= MO_DIV);
        n_s7.m = r_s6.nneg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    // Stage 8: day count of the months before this one.
    always_comb begin
        n_s8    = r_s7;
        n_s8.md = month_days($signed(r_s7.m));
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_s5 <= n_s5;
        end
        if (i_load[1]) begin
            r_s6 <= n_s6;
        end
        if (i_load[2]) begin
            r_s7 <= n_s7;
        end
        if (i_load[3]) begin
            r_s8 <= n_s8;
        end
    end

    assign o_work = r_s8;

endmodule

/* src/mjd_calendar_date_converter.sv */
// An accepted item moves through the stage registers in order into the output register.
// Throughput: one item per clock when not stalled; every stage is a plain register with
// its own valid bit. The rate is set by the nine-stage pipeline, in which each constant
// division is a reciprocal multiply in one stage and a remainder correction in the next.
// Reset (synchronous, active low) clears all valid bits; the data registers are not reset.
module mjd_calendar_date_converter
    import mjdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Stage control. Each stage moves when it is empty or when the stage after
    // it moves, so bubbles close up and an item can enter while a finished
    // result still waits at the output.
    t_ctl ctl;

    mjdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (ctl)
    );

    assign o_in_stall  = !ctl.in_rdy;
    assign o_out_valid = ctl.out_vld;

    // Stages 1 to 4: year quotient and its day count. The calendar-to-MJD
    // direction is short and finishes inside these stages as well.
    t_work yr_work;

    mjdc_yr u_yr (
        .i_clk  (i_clk),
        .i_load (ctl.load[STG_YR-1:0]),
        .i_item (i_in_item),
        .o_work (yr_work)
    );

    // Stages 5 to 8: month quotient and its day count.
    t_work mo_work;

    mjdc_mo u_mo (
        .i_clk  (i_clk),
        .i_load (ctl.load[STG_YR+STG_MO-1:STG_YR]),
        .i_work (yr_work),
        .o_work (mo_work)
    );

    // Stage 9: the day of month, the correction for months 14 and 15 (which
    // belong to January and February of the next year), and the output item.
    // The fields that do not belong to the chosen direction are driven to zero.
    t_out_item r_out;
    t_out_item n_out;

    always_comb begin
        logic signed [17:0] d;
        logic               k;
        logic signed [8:0]  yf;
        logic signed [5:0]  mf;
        d  = $signed(mo_work.u) - 18'($signed(mo_work.md));
        k  = ($signed(mo_work.m) == MONTH_WRAP0) || ($signed(mo_work.m) == MONTH_WRAP1);
        yf = $signed(mo_work.y) + $signed({8'b0, k});
        mf = $signed(mo_work.m) - 6'sd1 - (k ? MONTH_YEAR : 6'sd0);
        n_out = '0;
        if (mo_work.func == DIR_TO_MJD) begin
            n_out.mjd_out = mo_work.mjd1;
        end else begin
            n_out.year_out  = yf[7:0];
            n_out.month_out = mf[3:0];
            n_out.day_out   = d[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[NSTG-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

/* src/mjdc_chk.sv */
`include "mjd_calendar_date_converter_macros.svh"

module mjdc_chk
    import mjdc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A result that is held back stays put.
    `MJDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled result changed")

    // A date result carries no MJD, and an MJD result carries no date.
    `MJDC_ASSERT_NOW(a_one_dir, i_clk, i_rst_n, o_out_valid && ((o_out_item.year_out != 8'd0) || (o_out_item.month_out != 4'd0) || (o_out_item.day_out != 5'd0)), o_out_item.mjd_out == 16'd0, "result mixes both directions")

    // With no result waiting at the output, nothing can push back on the input.
    `MJDC_ASSERT_NOW(a_no_false_stall, i_clk, i_rst_n, !o_out_valid, !o_in_stall, "input stalled with empty output")

endmodule

bind mjd_calendar_date_converter mjdc_chk u_chk (.*);

/* sim/mjdc_date_monitor.sv */
`timescale 1ns / 1ps

// Watches both channels of the date converter, predicts each result from
// the accepted input item and compares it field by field in arrival order.
module mjdc_date_monitor
    import mjdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_pending,
    output int        o_fail_count
);

    t_out_item expected_dates[$];
    int        fail_total = 0;

    assign o_fail_count = fail_total;

    // Annex C conversion in exact integer arithmetic. SystemVerilog signed
    // division truncates toward zero, which the formulas require.
    function automatic t_out_item convert_date(input t_in_item it);
        t_out_item r;
        longint    mjd;
        longint    yr;
        longint    ydays;
        longint    mon;
        longint    dd;
        longint    adj;
        r = '0;
        if (t_dir'(it.func) == DIR_TO_DATE) begin
            mjd   = it.mjd_in;
            yr    = (100 * mjd - 1507820) / 36525;
            ydays = (yr * 1461) / 4;
            mon   = (10000 * mjd - 149561000 - 10000 * ydays) / 306001;
            dd    = mjd - 14956 - ydays - (mon * 306001) / 10000;
            adj   = (mon == 14 || mon == 15) ? 1 : 0;
            yr    = yr + adj;
            mon   = mon - 1 - 12 * adj;
            r.year_out  = yr[7:0];
            r.month_out = mon[3:0];
            r.day_out   = dd[4:0];
        end else begin
            yr  = it.year_in;
            mon = it.month_in;
            dd  = it.day_in;
            adj = (mon == 1 || mon == 2) ? 1 : 0;
            mjd = 14956 + dd + ((yr - adj) * 1461) / 4
                + ((mon + 1 + 12 * adj) * 306001) / 10000;
            r.mjd_out = mjd[15:0];
        end
        return r;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        fail_total++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            expected_dates.delete();
            o_pending <= 0;
        end else begin
            // The result side is handled first so that an item accepted in
            // this cycle can never be matched against a result in the same one.
            if (i_out_valid && !i_out_stall) begin
                if (expected_dates.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, i_out_item);
                end else begin
                    want = expected_dates.pop_front();
                    if (i_out_item.mjd_out !== want.mjd_out) begin
                        report_field("mjd_out", want.mjd_out, i_out_item.mjd_out);
                    end
                    if (i_out_item.year_out !== want.year_out) begin
                        report_field("year_out", want.year_out, i_out_item.year_out);
                    end
                    if (i_out_item.month_out !== want.month_out) begin
                        report_field("month_out", want.month_out, i_out_item.month_out);
                    end
                    if (i_out_item.day_out !== want.day_out) begin
                        report_field("day_out", want.day_out, i_out_item.day_out);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_dates.push_back(convert_date(i_in_item));
            end
            o_pending <= expected_dates.size();
        end
    end

endmodule

/* sim/tb_mjd_calendar_date_converter.sv */
`timescale 1ns / 1ps

// Top of the date converter bench. It makes the clock, the reset and the
// stimulus, shapes the traffic on both channels, and gives the verdict. All
// prediction and comparison lives in the monitor instantiated beside the block.
module tb_mjd_calendar_date_converter;
    import mjdc_pkg::*;

    // Number of random conversions after the directed ones.
    localparam int RANDOM_ITEMS = 1350;
    // Cycles without any accepted item on either channel before the run is
    // declared hung. The worst legal receiver stall is far shorter.
    localparam int HANG_LIMIT   = 5000;

    // Patterns the receiver picks among at random.
    typedef enum logic [1:0] {
        STALL_NONE     = 2'd0,
        STALL_LIGHT    = 2'd1,
        STALL_HEAVY    = 2'd2,
        STALL_PERIODIC = 2'd3
    } t_stall_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    int          pending_dates;
    int          mismatch_count;
    int          burst_left = 0;
    int          idle_cycles;
    t_stall_mode stall_mode = STALL_NONE;
    logic [15:0] stall_cycle = '0;
    t_in_item    dates_to_convert[$];

    always #5 i_clk = ~i_clk;

    mjd_calendar_date_converter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    mjdc_date_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_pending    (pending_dates),
        .o_fail_count (mismatch_count)
    );

    // The receiver switches between never stalling, stalling now and then,
    // stalling most of the time and a fixed periodic pattern. Holding each
    // mode for a while gives long runs of back-to-back results as well as
    // stretches where the pipeline fills up and pushes back on the sender.
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 16'd1;
        if (stall_cycle[7:0] == 8'd0) begin
            stall_mode <= t_stall_mode'($urandom_range(3));
        end
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                i_out_stall <= ($urandom_range(3) == 0);
            end
            STALL_HEAVY: begin
                i_out_stall <= ($urandom_range(3) != 0);
            end
            default: begin
                i_out_stall <= ((stall_cycle % 7) < 3);
            end
        endcase
    end

    // An MJD-to-date item. The fields that this direction ignores still get
    // random values so that their bits toggle as well.
    function automatic t_in_item to_date_item(input logic [15:0] mjd);
        t_in_item it;
        it.func     = DIR_TO_DATE;
        it.mjd_in   = mjd;
        it.year_in  = 8'($urandom());
        it.month_in = 4'($urandom());
        it.day_in   = 5'($urandom());
        return it;
    endfunction

    // A date-to-MJD item; the unused MJD field is random.
    function automatic t_in_item to_mjd_item(input logic [7:0] year, input logic [3:0] month,
                                             input logic [4:0] day);
        t_in_item it;
        it.func     = DIR_TO_MJD;
        it.mjd_in   = 16'($urandom());
        it.year_in  = year;
        it.month_in = month;
        it.day_in   = day;
        return it;
    endfunction

    // Random conversion. Most dates are well formed, with January and
    // February drawn more often because of their year adjustment; the rest
    // use the whole width of the month and day fields. MJD values mostly
    // lie in the documented range, with some below it and some at the top.
    function automatic t_in_item random_conversion();
        logic [15:0] mjd;
        logic [3:0]  month;
        logic [4:0]  day;
        if ($urandom_range(1) == 0) begin
            case ($urandom_range(9))
                0:       mjd = 16'($urandom_range(15078, 0));
                1:       mjd = 16'($urandom_range(65535, 65000));
                2:       mjd = 16'($urandom_range(15400, 15079));
                default: mjd = 16'($urandom_range(65535, 15079));
            endcase
            return to_date_item(mjd);
        end
        case ($urandom_range(9))
            0:       month = 4'($urandom());
            1, 2:    month = 4'($urandom_range(2, 1));
            default: month = 4'($urandom_range(12, 1));
        endcase
        day = ($urandom_range(7) == 0) ? 5'($urandom()) : 5'($urandom_range(31, 1));
        return to_mjd_item(8'($urandom()), month, day);
    endfunction

    // Offers one item and returns at the edge where it is taken. Items come
    // in bursts; between bursts valid drops for a random number of cycles.
    // A zero-length gap leaves valid high so it is never lowered and raised
    // in the same step.
    task automatic send_conversion(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(200, 40)
                                                  : $urandom_range(12, 1);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    // Stops offering items until every predicted result has come back. The
    // pending count is registered in the monitor and lags the last accepted
    // item, so it is read only after waiting on the clock.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_dates != 0);
    endtask

    // Hang detection: any cycle with an accepted item on either side resets
    // the count.
    initial begin
        idle_cycles = 0;
        wait (i_rst_n);
        while (idle_cycles < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        // MJD to date: the first and last in-range days, values below the
        // range that truncate toward zero from negative intermediates, the
        // top of the 16-bit field, and January, February and March of 2000
        // where the month wrap correction does or does not apply.
        dates_to_convert.push_back(to_date_item(16'd15079));
        dates_to_convert.push_back(to_date_item(16'd65535));
        dates_to_convert.push_back(to_date_item(16'd0));
        dates_to_convert.push_back(to_date_item(16'd1));
        dates_to_convert.push_back(to_date_item(16'd15078));
        dates_to_convert.push_back(to_date_item(16'd51544));
        dates_to_convert.push_back(to_date_item(16'd51603));
        dates_to_convert.push_back(to_date_item(16'd51604));
        dates_to_convert.push_back(to_date_item(16'd45000));
        dates_to_convert.push_back(to_date_item(16'd58849));

        // Date to MJD: year zero in January and February, where the adjusted
        // year goes negative, the largest year, months and days outside the
        // calendar, all-zero and all-ones fields, and a plain mid-year date.
        dates_to_convert.push_back(to_mjd_item(8'd0, 4'd1, 5'd1));
        dates_to_convert.push_back(to_mjd_item(8'd0, 4'd2, 5'd28));
        dates_to_convert.push_back(to_mjd_item(8'd0, 4'd3, 5'd1));
        dates_to_convert.push_back(to_mjd_item(8'd255, 4'd12, 5'd31));
        dates_to_convert.push_back(to_mjd_item(8'd255, 4'd1, 5'd1));
        dates_to_convert.push_back(to_mjd_item(8'd100, 4'd1, 5'd1));
        dates_to_convert.push_back(to_mjd_item(8'd0, 4'd0, 5'd0));
        dates_to_convert.push_back(to_mjd_item(8'd0, 4'd13, 5'd31));
        dates_to_convert.push_back(to_mjd_item(8'd255, 4'd15, 5'd31));
        dates_to_convert.push_back(to_mjd_item(8'd99, 4'd2, 5'd31));
        dates_to_convert.push_back(to_mjd_item(8'd124, 4'd6, 5'd0));
        dates_to_convert.push_back(to_mjd_item(8'd70, 4'd7, 5'd15));

        // Reset is held from the start and released once.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dates_to_convert[n]) begin
            send_conversion(dates_to_convert[n]);
        end
        // The pipeline empties completely once after the directed items and
        // once halfway through the random ones.
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_conversion(random_conversion());
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end
        end

        // Wait for the last results, then give a stray extra result time to
        // show up before the verdict.
        drain_results();
        repeat (NSTG + 4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/mjdc_pkg.sv
src/mjdc_ctrl.sv
src/mjdc_yr.sv
src/mjdc_mo.sv
src/mjd_calendar_date_converter.sv
src/mjdc_chk.sv
sim/mjdc_date_monitor.sv
sim/tb_mjd_calendar_date_converter.sv
